FILE: rtl/core/bdq_pkg.sv
// Shared codes and types for the bounded deque with search.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_BACK  = 3'd1;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd2;
  localparam logic [2:0] ACT_DEL_BACK  = 3'd3;
  localparam logic [2:0] ACT_SEARCH    = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic shift_back;
    logic load_tail;
    logic shift_front;
    logic search_load;
    logic scan_shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/bounded_deque_with_search.sv
// Top level of the bounded double-ended queue with search, built as a chain of cells.
//
// Channel   Direction  Handshake                    Payload
// command   in         start_i high, busy_o low     action_i, item_value_i
// result    out        done_o high for one cycle    status_o, found_o, match_position_o,
//                                                   entry_count_o, front_value_o, front_valid_o
//
// Inserts and front deletes update the cells at the accepting edge, back deletes only
// the count and unused codes nothing; each shows its result in the following cycle and
// a new transaction may be started in that cycle. A search registers a match flag in
// every cell, then shifts the flags towards the front one cell a cycle until the first
// match reaches the front cell or no flag is set; busy_o is high meanwhile.
// Reset empties the deque; the receiver cannot stall results.
`timescale 1ns / 1ps
module bounded_deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic [3:0]         match_position_o,
  output logic [4:0]         entry_count_o,
  output logic signed [31:0] front_value_o,
  output logic               front_valid_o
);
  import bdq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [1:0]        status_q, status_d;
  logic              found_q, found_d;
  logic              done_q, done_d;
  cell_ctrl_t        ctrl;
  logic              accept;
  logic              full, empty;
  logic [DATA_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  logic [31:0]       pos_ext, count_ext;

  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    status_d = ST_DONE;
    found_d  = 1'b0;
    done_d   = 1'b0;
    ctrl     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          pos_d  = '0;
          case (action_i)
            ACT_INS_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.shift_back = 1'b1;
                count_d         = count_q + CntW'(1);
              end
            end
            ACT_INS_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.load_tail = 1'b1;
                count_d        = count_q + CntW'(1);
              end
            end
            ACT_DEL_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                ctrl.shift_front = 1'b1;
                count_d          = count_q - CntW'(1);
              end
            end
            ACT_DEL_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            ACT_SEARCH: begin
              ctrl.search_load = 1'b1;
              done_d           = 1'b0;
              state_d          = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cell_match[0]) begin
          found_d = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (cell_match == '0) begin
          pos_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctrl.scan_shift = 1'b1;
          pos_d           = pos_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pos_q    <= '0;
      status_q <= ST_DONE;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      status_q <= status_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] front_side;
    logic [DATA_W-1:0] back_side;
    logic              back_match;

    if (i == 0) begin : g_head
      assign front_side = item_value_i;
    end else begin : g_body
      assign front_side = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign back_side  = '0;
      assign back_match = 1'b0;
    end else begin : g_inner
      assign back_side  = cell_value[i+1];
      assign back_match = cell_match[i+1];
    end

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .item_i       (item_value_i),
      .front_side_i (front_side),
      .back_side_i  (back_side),
      .back_match_i (back_match),
      .occupied_i   (CntW'(i) < count_q),
      .write_here_i (CntW'(i) == count_q),
      .value_o      (cell_value[i]),
      .match_o      (cell_match[i])
    );
  end

  assign pos_ext   = 32'(pos_q);
  assign count_ext = 32'(count_q);

  assign busy_o           = (state_q == S_SCAN);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign match_position_o = pos_ext[3:0];
  assign entry_count_o    = count_ext[4:0];
  assign front_valid_o    = !empty;
  assign front_value_o    = empty ? '0 : cell_value[0];

endmodule

FILE: rtl/core/bdq_cell.sv
// One storage cell of the deque chain, holding a word and a search match flag.
`timescale 1ns / 1ps
module bdq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bdq_pkg::cell_ctrl_t           ctrl_i,
  input  logic [bdq_pkg::DATA_W-1:0]    item_i,
  input  logic [bdq_pkg::DATA_W-1:0]    front_side_i,
  input  logic [bdq_pkg::DATA_W-1:0]    back_side_i,
  input  logic                          back_match_i,
  input  logic                          occupied_i,
  input  logic                          write_here_i,
  output logic [bdq_pkg::DATA_W-1:0]    value_o,
  output logic                          match_o
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] value_q, value_d;
  logic              match_q, match_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift_back) begin
      value_d = front_side_i;
    end else if (ctrl_i.shift_front) begin
      value_d = back_side_i;
    end else if (ctrl_i.load_tail && write_here_i) begin
      value_d = item_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.search_load) begin
      match_d = occupied_i && (value_q == item_i);
    end else if (ctrl_i.scan_shift) begin
      match_d = back_match_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

FILE: rtl/core/bdq_checker.sv
// Port-level checks for the bounded deque with search, bound to the top level.
`timescale 1ns / 1ps
module bdq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [2:0]         action_i,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic [4:0]         entry_count_o
);
  import bdq_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // Every transaction other than a search reports in the very next cycle.
  a_quick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i != ACT_SEARCH) |=> done_o)
    else $error("non-search transaction did not report in the next cycle");

  // A search holds the block busy, with no result, in the cycle after it is accepted.
  a_search_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ACT_SEARCH) |=> busy_o && !done_o)
    else $error("search did not hold the block busy");

  // An insert either is refused as full or grows the count by one.
  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ACT_INS_FRONT || action_i == ACT_INS_BACK) |=>
      done_o && (status_o == ST_FULL ||
                 entry_count_o == 5'($past(entry_count_o) + 5'd1)))
    else $error("insert gave a wrong count");

  // A result is only shown once the block is free again.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .action_i      (action_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);
